FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off during reset.
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Implication into the next cycle, always on.
`define ASSERT_NEXT(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: sv/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Types and constants of the indexed doubly linked list.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int ID_W          = 10;
  localparam int MAX_NODES_DEF = 1024;
  localparam int CNT_REG_IDX   = 0;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_DEL   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t         op;
    logic [ID_W-1:0] x;
    logic [ID_W-1:0] y;
    logic            x_ok;
    logic            y_ok;
    logic            same;
  } item_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RDX,
    S_RDY,
    S_W1,
    S_W2,
    S_W3,
    S_OUT
  } state_t;

endpackage

FILE: sv/indexed_doubly_linked_list.sv
// A query or ignored op runs S_RDX, S_RDY and S_OUT; a delete adds S_W1 and S_W2, a move S_W1 to S_W3.
// The back end takes a new item only after the result beat of the last one is loaded in S_OUT.
// Input beats are queued two deep, so up to two are taken while the back end is busy.
// Reset and every node_count write start a rebuild sweep over all MAX_NODES entries, one entry
// a cycle, during which queued items wait.
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Doubly linked list over node ids with an APB register for the node count.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list #(
  parameter int MAX_NODES = idll_pkg::MAX_NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [idll_pkg::ID_W-1:0] node_x,
  input  logic [idll_pkg::ID_W-1:0] node_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      applied,
  output logic [idll_pkg::ID_W-1:0] list_head,
  output logic                      x_present,
  output logic [idll_pkg::ID_W-1:0] x_pred,
  output logic [idll_pkg::ID_W-1:0] x_succ
);
  import idll_pkg::*;

  item_t           q_item;
  logic            q_valid;
  logic            q_pop;
  logic            cfg_we;
  logic            reg_hit;
  logic [ID_W-1:0] node_count;

  assign pready  = 1'b1;
  assign reg_hit = (32'(paddr[2]) == CNT_REG_IDX);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? 32'(node_count) : '0;

  idll_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode  (opcode),
    .node_x  (node_x),
    .node_y  (node_y),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  idll_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (pwdata[ID_W-1:0]),
    .node_count(node_count),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .applied   (applied),
    .list_head (list_head),
    .x_present (x_present),
    .x_pred    (x_pred),
    .x_succ    (x_succ)
  );

endmodule

FILE: sv/idll_front.sv
// ----------------------------------------------------------------------------
// idll_front
// Takes input beats, classifies the node ids and queues them, two deep.
// ----------------------------------------------------------------------------
module idll_front #(
  parameter int MAX_NODES = idll_pkg::MAX_NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [idll_pkg::ID_W-1:0] node_x,
  input  logic [idll_pkg::ID_W-1:0] node_y,
  output logic                      q_valid,
  output idll_pkg::item_t           q_item,
  input  logic                      q_pop
);
  import idll_pkg::*;

  item_t      fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.op   = opcode_t'(opcode);
    cls.x    = node_x;
    cls.y    = node_y;
    cls.x_ok = (node_x != '0) && (32'(node_x) < MAX_NODES);
    cls.y_ok = (node_y != '0) && (32'(node_y) < MAX_NODES);
    cls.same = (node_x == node_y);
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: sv/idll_back.sv
// ----------------------------------------------------------------------------
// idll_back
// Pointer tables, presence memory and head; runs each queued operation
// as a short read / write sequence and holds the result beat.
// ----------------------------------------------------------------------------
module idll_back #(
  parameter int MAX_NODES = idll_pkg::MAX_NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [idll_pkg::ID_W-1:0] cfg_data,
  output logic [idll_pkg::ID_W-1:0] node_count,
  input  logic                      q_valid,
  input  idll_pkg::item_t           q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      applied,
  output logic [idll_pkg::ID_W-1:0] list_head,
  output logic                      x_present,
  output logic [idll_pkg::ID_W-1:0] x_pred,
  output logic [idll_pkg::ID_W-1:0] x_succ
);
  import idll_pkg::*;

  localparam int IW = $clog2(MAX_NODES);

  logic [ID_W-1:0] pred_mem [MAX_NODES];
  logic [ID_W-1:0] succ_mem [MAX_NODES];
  logic            pres_mem [MAX_NODES];

  state_t          state, state_next;
  logic [IW-1:0]   sw_idx;
  logic [ID_W-1:0] head;
  item_t           it;
  logic [ID_W-1:0] px, nx, yp, yn;
  logic            prx;
  logic            res_app, res_pres;
  logic [ID_W-1:0] res_pred, res_succ;

  logic [IW-1:0]   rd_addr;
  logic [ID_W-1:0] pred_rd, succ_rd;
  logic            pres_rd;
  logic            pred_we, succ_we, pres_we;
  logic [IW-1:0]   pred_wa, succ_wa, pres_wa;
  logic [ID_W-1:0] pred_wd, succ_wd;
  logic            pres_wd;
  logic            out_load;

  logic            sw_pres;
  logic [ID_W-1:0] sw_pred, sw_succ, cnt_sat;
  logic            x_live, y_live, do_it, is_move;
  logic [ID_W-1:0] yp_n, yn_n;

  assign cnt_sat = (32'(cfg_data) > MAX_NODES - 1) ? ID_W'(MAX_NODES - 1) : cfg_data;

  assign sw_pres = (sw_idx != '0) && (32'(sw_idx) <= 32'(node_count));
  assign sw_pred = sw_pres ? ID_W'(sw_idx - 1'b1) : '0;
  assign sw_succ = (sw_pres && (32'(sw_idx) < 32'(node_count))) ? ID_W'(sw_idx + 1'b1) : '0;

  assign is_move = (it.op == OP_LEFT) || (it.op == OP_RIGHT);
  assign x_live  = it.x_ok && prx;
  assign y_live  = it.y_ok && pres_rd;
  assign do_it   = is_move ? (x_live && y_live && !it.same) : ((it.op == OP_DEL) && x_live);
  assign yp_n    = (nx == it.y) ? px : pred_rd;
  assign yn_n    = (px == it.y) ? nx : succ_rd;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_wa] <= pred_wd;
    end
    pred_rd <= pred_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[succ_wa] <= succ_wd;
    end
    succ_rd <= succ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
    pres_rd <= pres_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else if (cfg_we) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_addr    = IW'(it.x);
    pred_we    = 1'b0;
    succ_we    = 1'b0;
    pres_we    = 1'b0;
    pred_wa    = IW'(it.x);
    succ_wa    = IW'(it.x);
    pres_wa    = IW'(it.x);
    pred_wd    = '0;
    succ_wd    = '0;
    pres_wd    = 1'b0;
    unique case (state)
      S_SWEEP: begin
        pred_we = 1'b1;
        succ_we = 1'b1;
        pres_we = 1'b1;
        pred_wa = sw_idx;
        succ_wa = sw_idx;
        pres_wa = sw_idx;
        pred_wd = sw_pred;
        succ_wd = sw_succ;
        pres_wd = sw_pres;
        if (sw_idx == IW'(MAX_NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = IW'(q_item.x);
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_RDX;
        end
      end
      S_RDX: begin
        rd_addr    = IW'(it.y);
        state_next = S_RDY;
      end
      S_RDY: begin
        state_next = do_it ? S_W1 : S_OUT;
      end
      S_W1: begin
        succ_we    = (px != '0);
        succ_wa    = IW'(px);
        succ_wd    = nx;
        pred_we    = (nx != '0);
        pred_wa    = IW'(nx);
        pred_wd    = px;
        state_next = S_W2;
      end
      S_W2: begin
        pred_we = 1'b1;
        succ_we = 1'b1;
        if (it.op == OP_LEFT) begin
          pred_wd = yp;
          succ_wd = it.y;
        end else if (it.op == OP_RIGHT) begin
          pred_wd = it.y;
          succ_wd = yn;
        end else begin
          pres_we = 1'b1;
        end
        state_next = (it.op == OP_DEL) ? S_OUT : S_W3;
      end
      S_W3: begin
        if (it.op == OP_LEFT) begin
          pred_we = 1'b1;
          pred_wa = IW'(it.y);
          pred_wd = it.x;
          succ_we = (yp != '0);
          succ_wa = IW'(yp);
          succ_wd = it.x;
        end else begin
          succ_we = 1'b1;
          succ_wa = IW'(it.y);
          succ_wd = it.x;
          pred_we = (yn != '0);
          pred_wa = IW'(yn);
          pred_wd = it.x;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      head       <= '0;
      sw_idx     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cnt_sat;
        head       <= (cnt_sat != '0) ? ID_W'(1) : '0;
        sw_idx     <= '0;
      end else if (state == S_SWEEP) begin
        sw_idx <= sw_idx + 1'b1;
      end else if (state == S_W1 && px == '0) begin
        head <= nx;
      end else if (state == S_W3 && it.op == OP_LEFT && yp == '0) begin
        head <= it.x;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_item;
    end
    if (state == S_RDX) begin
      px  <= pred_rd;
      nx  <= succ_rd;
      prx <= pres_rd;
    end
    if (state == S_RDY) begin
      yp      <= yp_n;
      yn      <= yn_n;
      res_app <= do_it;
      if (!do_it) begin
        res_pres <= x_live;
        res_pred <= x_live ? px : '0;
        res_succ <= x_live ? nx : '0;
      end else if (it.op == OP_LEFT) begin
        res_pres <= 1'b1;
        res_pred <= yp_n;
        res_succ <= it.y;
      end else if (it.op == OP_RIGHT) begin
        res_pres <= 1'b1;
        res_pred <= it.y;
        res_succ <= yn_n;
      end else begin
        res_pres <= 1'b0;
        res_pred <= '0;
        res_succ <= '0;
      end
    end
    if (out_load) begin
      applied   <= res_app;
      list_head <= head;
      x_present <= res_pres;
      x_pred    <= res_pred;
      x_succ    <= res_succ;
    end
  end

endmodule

FILE: sv/idll_checker.sv
// ----------------------------------------------------------------------------
// idll_checker
// Port level checks on the result beats of the linked list.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idll_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      x_present,
  input logic [idll_pkg::ID_W-1:0] list_head,
  input logic [idll_pkg::ID_W-1:0] x_pred,
  input logic [idll_pkg::ID_W-1:0] x_succ
);

  `ASSERT_NEXT(a_rst_clears, clk, rst, !out_valid)
  `ASSERT_IMPLY(a_hold, clk, rst, out_valid && out_stall, ##1 out_valid)
  `ASSERT_IMPLY(a_absent_zero, clk, rst, out_valid && !x_present, x_pred == '0 && x_succ == '0)
  `ASSERT_IMPLY(a_nbr_differ, clk, rst, out_valid && x_present, x_pred != x_succ || x_pred == '0)
  `ASSERT_IMPLY(a_empty_absent, clk, rst, out_valid && list_head == '0, !x_present)

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (.*);
